FILE: design/twm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package twm_pkg;

	localparam int SampleWidth = 16;
	localparam int SumWidth    = 32;
	localparam int CountWidth  = 16;
	localparam int KindWidth   = 2;
	localparam int IndexWidth  = 2;

	localparam logic [KindWidth-1:0] KIND_ABOVE = 2'd0;
	localparam logic [KindWidth-1:0] KIND_BELOW = 2'd1;
	localparam logic [KindWidth-1:0] KIND_AVG   = 2'd2;

	localparam logic [IndexWidth-1:0] REG_LIMIT_HIGH     = 2'd0;
	localparam logic [IndexWidth-1:0] REG_LIMIT_LOW      = 2'd1;
	localparam logic [IndexWidth-1:0] REG_AVERAGE_PERIOD = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ALERT,
		S_DIV,
		S_AVG
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

FILE: design/temperature_window_monitor.sv
`timescale 1ns / 1ps
`default_nettype none

// Window comparator with block average. Each sample is checked against limit_high and
// limit_low; the first sample strictly outside the window gives one alert transaction
// (above wins when the limits cross), and a sample inside the window rearms both alerts.
// Samples are counted and summed; when the count equals average_period the block gives
// an average transaction (sum / count, truncated toward zero, low 16 bits) and clears
// count and sum. An alert comes before the average, and last marks the final result of
// a sample. A sample that ends a period waits on the serial divider, which retires one
// quotient bit per cycle, and on output stalls; in_ready is low until all its results
// are taken. Configuration writes are always taken and apply from the next sample.
module temperature_window_monitor (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [twm_pkg::IndexWidth-1:0]      cfg_index,
	input  wire logic [twm_pkg::SampleWidth-1:0]     cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [twm_pkg::SampleWidth-1:0] sample,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [twm_pkg::KindWidth-1:0]            report_kind,
	output logic signed [twm_pkg::SampleWidth-1:0]   report_value,
	output logic                                     last
);
	import twm_pkg::*;

	logic signed [SampleWidth-1:0] limit_high_q;
	logic signed [SampleWidth-1:0] limit_low_q;
	logic [CountWidth-1:0]         period_q;
	logic [CountWidth-1:0]         count_q;
	logic [SumWidth-1:0]           sum_q;
	logic                          above_q;
	logic                          below_q;
	logic                          avg_pend_q;
	logic [KindWidth-1:0]          kind_q;
	logic [SampleWidth-1:0]        value_q;
	logic                          last_q;

	state_t state_q;
	state_t state_d;

	logic                   accept;
	logic                   is_above;
	logic                   is_below;
	logic                   alert;
	logic                   avg_due;
	logic                   load_avg;
	logic [CountWidth-1:0]  count_next;
	logic [SumWidth-1:0]    sum_next;
	div_status_t            div_st;
	logic [SampleWidth-1:0] div_q;

	assign cfg_ready = 1'b1;

	always_comb begin
		accept     = in_valid && in_ready;
		is_above   = sample > limit_high_q;
		is_below   = sample < limit_low_q;
		alert      = is_above ? !above_q : (is_below && !below_q);
		count_next = count_q + CountWidth'(1);
		sum_next   = sum_q + {{(SumWidth-SampleWidth){sample[SampleWidth-1]}}, sample};
		avg_due    = (period_q != '0) && (count_next == period_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_high_q <= 16'sh7fff;
			limit_low_q  <= 16'sh8000;
			period_q     <= CountWidth'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LIMIT_HIGH:     limit_high_q <= cfg_data;
				REG_LIMIT_LOW:      limit_low_q  <= cfg_data;
				REG_AVERAGE_PERIOD: period_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			sum_q      <= '0;
			above_q    <= 1'b0;
			below_q    <= 1'b0;
			avg_pend_q <= 1'b0;
		end else if (accept) begin
			count_q    <= avg_due ? '0 : count_next;
			sum_q      <= avg_due ? '0 : sum_next;
			avg_pend_q <= avg_due;
			priority if (is_above) begin
				above_q <= 1'b1;
			end else if (is_below) begin
				below_q <= 1'b1;
			end else begin
				above_q <= 1'b0;
				below_q <= 1'b0;
			end
		end
	end

	twm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && avg_due),
		.dividend (sum_next),
		.divisor  (count_next),
		.status   (div_st),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		load_avg  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					priority if (alert) begin
						state_d = S_ALERT;
					end else if (avg_due) begin
						state_d = S_DIV;
					end
				end
			end
			S_ALERT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = avg_pend_q ? S_DIV : S_IDLE;
				end
			end
			S_DIV: begin
				if (div_st.done) begin
					load_avg = 1'b1;
					state_d  = S_AVG;
				end
			end
			S_AVG: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && alert) begin
			kind_q  <= is_above ? KIND_ABOVE : KIND_BELOW;
			value_q <= sample;
			last_q  <= !avg_due;
		end else if (load_avg) begin
			kind_q  <= KIND_AVG;
			value_q <= div_q;
			last_q  <= 1'b1;
		end
	end

	assign report_kind  = kind_q;
	assign report_value = value_q;
	assign last         = last_q;

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	a_div_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_st.busy || div_st.done))
		else $error("waiting on a divider that was never started");

	a_avg_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && report_kind == KIND_AVG) |-> last)
		else $error("average transaction not marked last");

	a_alert_then_avg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALERT && out_ready && avg_pend_q) |=> (state_q == S_DIV))
		else $error("average lost after alert");

endmodule

`default_nettype wire

FILE: design/twm_div.sv
`timescale 1ns / 1ps
`default_nettype none

module twm_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [twm_pkg::SumWidth-1:0]     dividend,
	input  wire logic [twm_pkg::CountWidth-1:0]   divisor,
	output twm_pkg::div_status_t                  status,
	output logic [twm_pkg::SampleWidth-1:0]       quotient
);
	import twm_pkg::*;

	localparam int StepWidth = $clog2(SumWidth);

	logic                  busy_q;
	logic                  done_q;
	logic [StepWidth-1:0]  cnt_q;
	logic [CountWidth-1:0] rem_q;
	logic [CountWidth-1:0] den_q;
	logic [SumWidth-1:0]   quo_q;
	logic                  neg_q;

	logic [CountWidth:0]   trial;
	logic [CountWidth:0]   diff;
	logic                  ge;
	logic [SumWidth-1:0]   mag;

	always_comb begin
		trial = {rem_q, quo_q[SumWidth-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
		mag   = dividend[SumWidth-1] ? (SumWidth'(0) - dividend) : dividend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= StepWidth'(SumWidth - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - StepWidth'(1);
			end
		end
	end

	// one restoring step per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag;
			den_q <= divisor;
			neg_q <= dividend[SumWidth-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[CountWidth-1:0] : trial[CountWidth-1:0];
			quo_q <= {quo_q[SumWidth-2:0], ge};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = neg_q ? (SampleWidth'(0) - quo_q[SampleWidth-1:0])
	                           : quo_q[SampleWidth-1:0];

endmodule

`default_nettype wire

FILE: tb/temperature_window_monitor_test.sv
`timescale 1ns / 1ps

module temperature_window_monitor_test;

	import twm_pkg::*;

	localparam logic [IndexWidth-1:0] REG_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 265;

	typedef struct packed {
		logic [KindWidth-1:0] kind;
		logic signed [SampleWidth-1:0] value;
		logic last;
	} report_t;

	class report_scoreboard;
		logic signed [SampleWidth-1:0] limit_high;
		logic signed [SampleWidth-1:0] limit_low;
		logic [CountWidth-1:0] average_period;
		logic [CountWidth-1:0] count;
		logic [SumWidth-1:0] sum;
		bit above;
		bit below;
		int averages;
		int errors;
		report_t expected[$];

		function new();
			limit_high = 16'sh7FFF;
			limit_low = 16'sh8000;
			average_period = 16'd1;
			count = '0;
			sum = '0;
			above = 1'b0;
			below = 1'b0;
			averages = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [IndexWidth-1:0] idx, logic [SampleWidth-1:0] data);
			case (idx)
				REG_LIMIT_HIGH: limit_high = data;
				REG_LIMIT_LOW: limit_low = data;
				REG_AVERAGE_PERIOD: average_period = data;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected.size();
		endfunction

		// predict the reports caused by one accepted sample
		function void note_sample(logic signed [SampleWidth-1:0] s);
			report_t alert;
			report_t avg;
			bit has_alert;
			bit has_avg;
			logic [SumWidth-1:0] mag;
			logic [SumWidth-1:0] quo;
			has_alert = 1'b0;
			has_avg = 1'b0;
			alert = '0;
			avg = '0;
			count = count + 1'b1;
			sum = sum + {{(SumWidth - SampleWidth){s[SampleWidth-1]}}, s};
			if (s > limit_high) begin
				if (!above) begin
					above = 1'b1;
					has_alert = 1'b1;
					alert.kind = KIND_ABOVE;
					alert.value = s;
				end
			end else if (s < limit_low) begin
				if (!below) begin
					below = 1'b1;
					has_alert = 1'b1;
					alert.kind = KIND_BELOW;
					alert.value = s;
				end
			end else begin
				above = 1'b0;
				below = 1'b0;
			end
			if (average_period != 0 && count == average_period) begin
				mag = sum[SumWidth-1] ? -sum : sum;
				quo = mag / {{(SumWidth - CountWidth){1'b0}}, count};
				if (sum[SumWidth-1])
					quo = -quo;
				has_avg = 1'b1;
				avg.kind = KIND_AVG;
				avg.value = quo[SampleWidth-1:0];
				avg.last = 1'b1;
				count = '0;
				sum = '0;
				averages++;
			end
			if (has_alert) begin
				alert.last = !has_avg;
				expected.push_back(alert);
			end
			if (has_avg)
				expected.push_back(avg);
		endfunction

		function void check_report(logic [KindWidth-1:0] kind, logic signed [SampleWidth-1:0] value,
				logic last_bit);
			report_t want;
			if (expected.size() == 0) begin
				$error("unexpected report: report_kind %0d report_value %0d last %0d",
					kind, value, last_bit);
				errors++;
				return;
			end
			want = expected.pop_front();
			if (kind !== want.kind) begin
				$error("report_kind mismatch: expected %0d, actual %0d", want.kind, kind);
				errors++;
			end
			if (value !== want.value) begin
				$error("report_value mismatch: expected %0d, actual %0d", want.value, value);
				errors++;
			end
			if (last_bit !== want.last) begin
				$error("last mismatch: expected %0d, actual %0d", want.last, last_bit);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IndexWidth-1:0] cfg_index = '0;
	logic [SampleWidth-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SampleWidth-1:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [KindWidth-1:0] report_kind;
	logic signed [SampleWidth-1:0] report_value;
	logic last;

	report_scoreboard sb;
	bit idle_on = 1'b0;
	bit hold_output = 1'b0;
	int quiet_cycles = 0;

	temperature_window_monitor dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.report_kind(report_kind),
		.report_value(report_value),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_sample(input logic signed [SampleWidth-1:0] s);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_sample(s);
	endtask

	task automatic write_reg(input logic [IndexWidth-1:0] idx, input logic [SampleWidth-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic signed [SampleWidth-1:0] hi,
			input logic signed [SampleWidth-1:0] lo, input logic [CountWidth-1:0] period);
		drain();
		write_reg(REG_SPARE, SampleWidth'($urandom));
		write_reg(REG_LIMIT_HIGH, hi);
		write_reg(REG_LIMIT_LOW, lo);
		write_reg(REG_AVERAGE_PERIOD, period);
		cfg_valid <= 1'b0;
	endtask

	// result side: random back-pressure plus one long hold-off on request
	initial begin
		forever begin
			if (hold_output) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_report(report_kind, report_value, last);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int n;
		int phase;
		int v;
		int base;
		logic signed [SampleWidth-1:0] s;
		logic signed [SampleWidth-1:0] hi;
		logic signed [SampleWidth-1:0] lo;
		logic [CountWidth-1:0] period;

		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;

		// reset settings: every sample is its own average, no alerts
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh0000);
		send_sample(16'sh5555);
		send_sample(-16'sd1);

		// window alerts, rearm and alert followed by average
		configure(16'sd100, -16'sd100, 16'd4);
		send_sample(16'sd101);
		send_sample(16'sh7FFF);
		send_sample(16'sd100);
		send_sample(-16'sd101);
		send_sample(16'sh8000);
		send_sample(16'sd0);
		send_sample(-16'sd100);
		send_sample(16'sd5);

		// crossed limits, above test wins
		configure(-16'sd100, 16'sd100, 16'd3);
		send_sample(16'sd0);
		send_sample(-16'sd200);
		send_sample(16'sd0);
		send_sample(16'sd200);
		send_sample(-16'sd101);

		// zero period: count and sum run on with no average
		configure(16'sh7FFF, 16'sh8000, 16'd0);
		idle_on = 1'b0;
		for (n = 0; n < 30; n++) begin
			s = SampleWidth'($urandom_range(30000, 32767));
			send_sample(s);
		end
		// period below the running count: no average until the count wraps
		configure(16'sh7FFF, 16'sh8000, 16'd20);
		for (n = 0; n < 10; n++) begin
			s = SampleWidth'($urandom_range(30000, 32767));
			send_sample(s);
		end

		configure(16'sh7FFF, 16'sh8000, 16'hFFFF);
		idle_on = 1'b1;
		send_sample(16'sh7FFF);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		configure(16'sh8000, 16'sh7FFF, 16'd4);
		send_sample(16'sh0001);

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 3))
				0: begin
					hi = SampleWidth'($urandom);
					lo = SampleWidth'($urandom);
				end
				1: begin
					base = int'($urandom_range(0, 2000)) - 1000;
					lo = SampleWidth'(base);
					hi = SampleWidth'(base + int'($urandom_range(0, 400)));
				end
				2: begin
					if ($urandom_range(0, 1)) begin
						hi = 16'sh7FFF;
						lo = 16'sh8000;
					end else begin
						hi = 16'sh8000;
						lo = 16'sh7FFF;
					end
				end
				default: begin
					base = int'($urandom_range(0, 600)) - 300;
					lo = SampleWidth'(base);
					hi = SampleWidth'(base - int'($urandom_range(1, 50)));
				end
			endcase
			if (phase == 0)
				period = sb.count + 1'b1;
			else if ($urandom_range(0, 3) == 0)
				period = sb.count + CountWidth'($urandom_range(1, 40));
			else
				period = sb.count + CountWidth'($urandom_range(1, 6));
			idle_on = (phase == RANDOM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
			configure(hi, lo, period);
			if (phase == 0) begin
				idle_on = 1'b1;
				hold_output = 1'b1;
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				case ($urandom_range(0, 9))
					0, 1, 2: v = int'(hi) + int'($urandom_range(0, 6)) - 3;
					3, 4, 5: v = int'(lo) + int'($urandom_range(0, 6)) - 3;
					6, 7: v = int'($urandom_range(0, 65535)) - 32768;
					8: v = $urandom_range(0, 1) ? 32767 : -32768;
					default: v = int'($urandom_range(0, 64)) - 32;
				endcase
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				s = v[SampleWidth-1:0];
				send_sample(s);
			end
		end

		drain();
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
design/twm_pkg.sv
design/twm_div.sv
design/temperature_window_monitor.sv
tb/temperature_window_monitor_test.sv
